### hdl/assert_macros.svh
// Assertion macros used by the top level of the datetime-to-epoch block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define RDE_ASSERT_ALWAYS(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) (expr)) \
    else $error("rde assertion failed: invariant");

// Check that the consequent holds in the same cycle as the antecedent.
`define RDE_ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rde assertion failed: implication");

`endif

### hdl/rde_pkg.sv
// Shared types, constants and calendar helpers for the datetime-to-epoch block.
`default_nettype none

package rde_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [14:0] EPOCH_YEAR    = 15'd1970;
  localparam logic [14:0] LAST_YEAR     = 15'd9999;
  localparam logic [23:0] DAYS_TO_EPOCH = 24'd719162;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [12:0] DIV100_MUL    = 13'd5243;
  localparam int          DIV100_SHIFT  = 19;

  // Decoded sample handed from the front end to the back end.
  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hr;
    logic [7:0]  day;
    logic [3:0]  mon;
    logic [14:0] year;
    logic        ok;     // time fields and month in range
  } rde_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rde_qstat_t;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    logic [7:0] hi;
    hi = {4'b0000, v[7:4]};
    return {4'b0000, v[3:0]} + (hi << 3) + (hi << 1);
  endfunction

  // Days in the year before the first of the month.
  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] mon, input logic leap);
    logic [4:0] d;
    unique case (mon)
      4'd2:                     d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### hdl/rtc_datetime_to_epoch_seconds_top.sv
// Top level: converts raw RTC date/time words into seconds since the Unix epoch.
//
// Input channel (in_valid / in_ready) carries one raw RTC sample per word:
// second, minute, hour, day, month, year and century bytes plus the
// binary_mode and hour_24_mode flags. Output channel (out_valid / out_ready)
// carries epoch_seconds and valid_res; an invalid date gives valid_res = 0
// and epoch_seconds = 0.
// Configuration: cfg_we writes cfg_wdata into century_present; write it only
// while the block is idle. Reset clears it to 0 (two-digit year rule).
// Registers from input accept to output valid: front register, queue entry,
// three back-end stages, output register.
// Throughput: one word per cycle while the receiver does not stall, set by the fully pipelined back end; the
// widest step is the 22 x 17 bit day-to-seconds multiply in the last stage.
// When the receiver stalls the back end fills, then the two-entry queue,
// then the front register, and only then in_ready drops; no word is lost.
// Synchronous reset empties the pipeline and the queue.
`default_nettype none
`include "assert_macros.svh"

module rtc_datetime_to_epoch_seconds_top
  import rde_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  raw_second,
  input  wire logic [7:0]  raw_minute,
  input  wire logic [7:0]  raw_hour,
  input  wire logic [7:0]  raw_day,
  input  wire logic [7:0]  raw_month,
  input  wire logic [7:0]  raw_year,
  input  wire logic [7:0]  raw_century,
  input  wire logic        binary_mode,
  input  wire logic        hour_24_mode,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [37:0]      epoch_seconds,
  output logic             valid_res
);

  logic       century_present;
  logic       f_valid, f_ready;
  rde_item_t  f_item;
  logic       b_valid, b_ready;
  rde_item_t  b_item;
  rde_qstat_t q_stat;

  // Hold the century mode until the next write.
  always_ff @(posedge clk) begin
    if (rst) begin
      century_present <= 1'b0;
    end else if (cfg_we) begin
      century_present <= cfg_wdata;
    end
  end

  rde_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_second      (raw_second),
    .raw_minute      (raw_minute),
    .raw_hour        (raw_hour),
    .raw_day         (raw_day),
    .raw_month       (raw_month),
    .raw_year        (raw_year),
    .raw_century     (raw_century),
    .binary_mode     (binary_mode),
    .hour_24_mode    (hour_24_mode),
    .century_present (century_present),
    .f_valid         (f_valid),
    .f_ready         (f_ready),
    .f_item          (f_item)
  );

  // Decouple decode from arithmetic so each side can stall on its own.
  rde_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item),
    .stat      (q_stat)
  );

  rde_back u_back (
    .clk           (clk),
    .rst           (rst),
    .b_valid       (b_valid),
    .b_ready       (b_ready),
    .b_item        (b_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .epoch_seconds (epoch_seconds),
    .valid_res     (valid_res)
  );

  // A rejected date must carry zero seconds.
  `RDE_ASSERT_IMPLIES(a_invalid_zero, clk, rst, out_valid && !valid_res, epoch_seconds == '0)
  // A valid result never passes 9999-12-31 23:59:59.
  `RDE_ASSERT_IMPLIES(a_result_range, clk, rst, out_valid && valid_res, epoch_seconds <= 38'd253402300799)
  // The queue can never be full and empty at once.
  `RDE_ASSERT_ALWAYS(a_queue_state, clk, rst, !(q_stat.full && q_stat.empty))
  // The front end only stalls while the queue is full.
  `RDE_ASSERT_IMPLIES(a_front_stall, clk, rst, f_valid && !f_ready, q_stat.full)

endmodule

`default_nettype wire

### hdl/rde_front.sv
// Front end: accept a raw sample, decode BCD and 12-hour fields, form the year.
`default_nettype none

module rde_front
  import rde_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  raw_second,
  input  wire logic [7:0]  raw_minute,
  input  wire logic [7:0]  raw_hour,
  input  wire logic [7:0]  raw_day,
  input  wire logic [7:0]  raw_month,
  input  wire logic [7:0]  raw_year,
  input  wire logic [7:0]  raw_century,
  input  wire logic        binary_mode,
  input  wire logic        hour_24_mode,
  input  wire logic        century_present,
  output logic             f_valid,
  input  wire logic        f_ready,
  output rde_item_t        f_item
);

  logic [7:0]  sec_d, min_d, day_d, mon_d, yr_d, cen_d, hr_base, hr_tmp, hr_d;
  logic [14:0] year_d;
  logic        time_ok, mon_ok;

  always_comb begin
    if (binary_mode) begin
      sec_d   = raw_second;
      min_d   = raw_minute;
      hr_base = {1'b0, raw_hour[6:0]};
      day_d   = raw_day;
      mon_d   = raw_month;
      yr_d    = raw_year;
      cen_d   = raw_century;
    end else begin
      sec_d   = bcd_to_bin(raw_second);
      min_d   = bcd_to_bin(raw_minute);
      hr_base = bcd_to_bin({1'b0, raw_hour[6:0]});
      day_d   = bcd_to_bin(raw_day);
      mon_d   = bcd_to_bin(raw_month);
      yr_d    = bcd_to_bin(raw_year);
      cen_d   = bcd_to_bin(raw_century);
    end
  end

  // Map 12 o'clock to 0, then add 12 for PM.
  always_comb begin
    hr_tmp = (hr_base == 8'd12) ? 8'd0 : hr_base;
    if (hour_24_mode) begin
      hr_d = hr_base;
    end else begin
      hr_d = raw_hour[7] ? hr_tmp + 8'd12 : hr_tmp;
    end
  end

  always_comb begin
    if (century_present && cen_d != 8'd0) begin
      year_d = 15'(cen_d) * 15'd100 + 15'(yr_d);
    end else if (yr_d < 8'd70) begin
      year_d = 15'd2000 + 15'(yr_d);
    end else begin
      year_d = 15'd1900 + 15'(yr_d);
    end
  end

  assign time_ok  = (hr_d <= 8'd23) && (min_d <= 8'd59) && (sec_d <= 8'd59);
  assign mon_ok   = (mon_d >= 8'd1) && (mon_d <= 8'd12);
  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (f_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item.sec  <= sec_d[5:0];
      f_item.min  <= min_d[5:0];
      f_item.hr   <= hr_d[4:0];
      f_item.day  <= day_d;
      f_item.mon  <= mon_d[3:0];
      f_item.year <= year_d;
      f_item.ok   <= time_ok && mon_ok;
    end
  end

endmodule

`default_nettype wire

### hdl/rde_queue.sv
// Short flop-based queue between the front end and the back end.
`default_nettype none

module rde_queue
  import rde_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire rde_item_t  in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output rde_item_t       out_item,
  output rde_qstat_t      stat
);

  rde_item_t           entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count, count_next;
  logic                push, pop;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign in_ready   = !stat.full;
  assign out_valid  = !stat.empty;
  assign out_item   = entry[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = out_valid && out_ready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

### hdl/rde_back.sv
// Back end: four-stage pipeline from decoded fields to epoch seconds.
`default_nettype none

module rde_back
  import rde_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       b_valid,
  output logic            b_ready,
  input  wire rde_item_t  b_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [37:0]     epoch_seconds,
  output logic            valid_res
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1: year / 100 by reciprocal, year range
  rde_item_t   s1;
  logic [8:0]  q1;
  logic        yok1;
  logic [27:0] q_prod;

  // Stage 2: leap year, year days, day of year
  logic [4:0]  hr2;
  logic [5:0]  min2, sec2;
  logic [23:0] ydays2;
  logic [8:0]  p100_2, doy2;
  logic        ok2;
  logic [15:0] q100;
  logic [14:0] rem, p;
  logic        rem_zero, leap;
  logic [8:0]  p100;
  logic [4:0]  mlen;
  logic        day_ok;
  logic [8:0]  doy;
  logic [23:0] ydays;

  // Stage 3: day count and time of day
  logic [21:0] days3;
  logic [16:0] tod3;
  logic        ok3;
  logic [23:0] days_full;
  logic [16:0] tod;

  // Stage 4: output register
  logic [38:0] day_secs;

  assign rdy4    = !out_valid || out_ready;
  assign rdy3    = !v3 || rdy4;
  assign rdy2    = !v2 || rdy3;
  assign rdy1    = !v1 || rdy2;
  assign b_ready = rdy1;

  assign q_prod = 28'(b_item.year) * 28'(DIV100_MUL);

  always_comb begin
    q100     = 16'(q1) * 16'd100;
    rem      = s1.year - q100[14:0];
    rem_zero = (rem == '0);
    leap     = (s1.year[1:0] == 2'b00) && (!rem_zero || q1[1:0] == 2'b00);
    p        = s1.year - 15'd1;
    p100     = q1 - 9'(rem_zero);
    mlen     = month_length(s1.mon, leap);
    day_ok   = (s1.day >= 8'd1) && (s1.day <= 8'(mlen));
    doy      = days_before_month(s1.mon) + 9'(leap && s1.mon > 4'd2)
               + 9'(s1.day) - 9'd1;
    ydays    = 24'(p) * 24'd365 + 24'(p >> 2);
  end

  always_comb begin
    days_full = ydays2 - 24'(p100_2) + 24'(p100_2 >> 2) - DAYS_TO_EPOCH + 24'(doy2);
    tod       = 17'(hr2) * 17'(SECS_PER_HOUR) + 17'(min2) * 17'd60 + 17'(sec2);
  end

  assign day_secs = 39'(days3) * 39'(SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= b_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1   <= b_item;
      q1   <= q_prod[DIV100_SHIFT +: 9];
      yok1 <= (b_item.year >= EPOCH_YEAR) && (b_item.year <= LAST_YEAR);
    end
    if (rdy2) begin
      hr2    <= s1.hr;
      min2   <= s1.min;
      sec2   <= s1.sec;
      ydays2 <= ydays;
      p100_2 <= p100;
      doy2   <= doy;
      ok2    <= s1.ok && yok1 && day_ok;
    end
    if (rdy3) begin
      days3 <= days_full[21:0];
      tod3  <= tod;
      ok3   <= ok2;
    end
    if (rdy4) begin
      epoch_seconds <= ok3 ? day_secs[37:0] + 38'(tod3) : '0;
      valid_res     <= ok3;
    end
  end

endmodule

`default_nettype wire
